[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define WSDA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define WSDA_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/wsda_pkg.sv]
package wsda_pkg;

    // Ring sizes.
    localparam int SPEED_DEPTH   = 16;
    localparam int AVERAGE_DEPTH = 64;

    localparam int SPD_AW    = (SPEED_DEPTH > 1) ? $clog2(SPEED_DEPTH) : 1;
    localparam int AVG_AW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SPD_WIN_W = $clog2(SPEED_DEPTH + 1);
    localparam int AVG_WIN_W = $clog2(AVERAGE_DEPTH + 1);

    localparam int SPD_SUM_W = $clog2(SPEED_DEPTH * 255 + 1);
    localparam int AVG_SUM_W = $clog2(AVERAGE_DEPTH * 255 + 1);
    localparam int DIR_SUM_W = $clog2(AVERAGE_DEPTH * 315 + 1);
    localparam int MAX_SUM_W = (SPD_SUM_W > AVG_SUM_W) ? SPD_SUM_W : AVG_SUM_W;
    localparam int DIV_NUM_W = (MAX_SUM_W > DIR_SUM_W) ? MAX_SUM_W : DIR_SUM_W;
    localparam int DIV_DEN_W = (SPD_WIN_W > AVG_WIN_W) ? SPD_WIN_W : AVG_WIN_W;

    // Fixed field widths.
    localparam int CNT_W      = 8;
    localparam int SECTOR_W   = 3;
    localparam int DEG_W      = 9;
    localparam int VANE_W     = 10;
    localparam int HIST_W     = CNT_W + SECTOR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;

    // Input transaction layout.
    localparam int S_LEVEL_BIT = 0;
    localparam int S_VANE_LSB  = 1;
    localparam int S_CLEAR_BIT = 11;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_INTERVAL   = 2'd0,
        CFG_AVERAGE_INTERVAL = 2'd1,
        CFG_SPEED_WINDOW     = 2'd2,
        CFG_AVERAGE_WINDOW   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_SUM,
        ST_SPD_DIV,
        ST_AVG_PUSH,
        ST_AVG_SUM,
        ST_AVG_DIV_SPD,
        ST_AVG_DIV_DIR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                match;
        logic [SECTOR_W-1:0] sector;
    } vane_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Vane references in test order, and their sectors (N=0 .. NW=7).
    localparam int NUM_REFS = 8;
    localparam logic [VANE_W-1:0] VANE_REFS [NUM_REFS] = '{
        10'd0, 10'd692, 10'd554, 10'd226, 10'd35, 10'd66, 10'd122, 10'd366
    };
    localparam logic [SECTOR_W-1:0] VANE_SECTORS [NUM_REFS] = '{
        3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };
    localparam logic [VANE_W-1:0] VANE_TOL = 10'd10;

    function automatic logic [DEG_W-1:0] sector_degrees(logic [SECTOR_W-1:0] s);
        case (s)
            3'd0:    return 9'd0;
            3'd1:    return 9'd45;
            3'd2:    return 9'd90;
            3'd3:    return 9'd135;
            3'd4:    return 9'd180;
            3'd5:    return 9'd225;
            3'd6:    return 9'd270;
            3'd7:    return 9'd315;
            default: return 9'd0;
        endcase
    endfunction

    // Zero counts as one, above depth saturates.
    function automatic logic [SPD_WIN_W-1:0] clamp_speed_window(logic [4:0] w);
        if (w == 5'd0) return SPD_WIN_W'(1);
        if (int'(w) > SPEED_DEPTH) return SPD_WIN_W'(SPEED_DEPTH);
        return SPD_WIN_W'(w);
    endfunction

    function automatic logic [AVG_WIN_W-1:0] clamp_average_window(logic [6:0] w);
        if (w == 7'd0) return AVG_WIN_W'(1);
        if (int'(w) > AVERAGE_DEPTH) return AVG_WIN_W'(AVERAGE_DEPTH);
        return AVG_WIN_W'(w);
    endfunction

    // Ring index arithmetic for any depth.
    function automatic int ring_back(int slot, int k, int depth);
        return (slot >= k) ? (slot - k) : (slot + depth - k);
    endfunction

    function automatic int ring_next(int slot, int depth);
        return (slot == depth - 1) ? 0 : (slot + 1);
    endfunction

endpackage

[rtl/wsda_ram.sv]
module wsda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/wsda_vane.sv]
module wsda_vane (
    input  logic [wsda_pkg::VANE_W-1:0] sample,
    output wsda_pkg::vane_result_t      result
);

    logic [wsda_pkg::VANE_W-1:0] delta;

    // Lowest matching reference wins; walk downward so it overrides.
    always_comb begin
        result = '0;
        delta  = '0;
        for (int i = wsda_pkg::NUM_REFS - 1; i >= 0; i--) begin
            if (sample >= wsda_pkg::VANE_REFS[i]) begin
                delta = sample - wsda_pkg::VANE_REFS[i];
            end else begin
                delta = wsda_pkg::VANE_REFS[i] - sample;
            end
            if (delta < wsda_pkg::VANE_TOL) begin
                result.match  = 1'b1;
                result.sector = wsda_pkg::VANE_SECTORS[i];
            end
        end
    end

endmodule

[rtl/wsda_divider.sv]
module wsda_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [wsda_pkg::DIV_NUM_W-1:0] num,
    input  logic [wsda_pkg::DIV_DEN_W-1:0] den,
    output wsda_pkg::div_status_t          status,
    output logic [wsda_pkg::DIV_NUM_W-1:0] quotient
);

    localparam int NW   = wsda_pkg::DIV_NUM_W;
    localparam int DW   = wsda_pkg::DIV_DEN_W;
    localparam int STPW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [STPW-1:0] step_reg, step_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        fits;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        diff      = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            rem_next  = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[NW-2:0], fits};
            step_next = step_reg - STPW'(1);
            if (step_reg == STPW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            step_next = STPW'(NW);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

[rtl/wind_speed_direction_averager.sv]
// Wind speed and direction averager. Each input transaction is one millisecond
// tick carrying the anemometer level, a raw vane reading and a clear-maximum flag;
// each tick returns exactly one result transaction with the current speed, the
// stored maximum and its direction, the window averages and the held vane
// direction. A plain tick is accepted and then goes to the finish step for its
// result. When the speed interval elapses, a speed pass comes first (Ws = clamped
// speed window: Ws - 1 ring reads at one per cycle, a drain of the last read, the
// divide start, then a divider run of 15 steps and its done; a window of one does
// no reads); when the average interval elapses, an average pass follows (one
// push, Wa history reads, a drain and a start, then two divides). The result may
// then wait for m_tready. All divisions run through one shared restoring divider
// and the sums through two accumulators under the sequencer; the block takes no
// new tick until the current one's result is registered, but a finished result
// may sit in the output register while the next tick is taken. Ring entries never
// written read as zero through per-entry valid bits, so no clearing pass is
// needed after reset. Configuration writes are accepted every cycle and must
// only be issued while the block is idle.
`include "assert_macros.svh"

module wind_speed_direction_averager (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Tick input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wsda_pkg::S_TDATA_W-1:0]  s_tdata,   // wind_level, vane_sample[9:0], clear_max
    // Result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wsda_pkg::M_TDATA_W-1:0]  m_tdata,   // wind_speed[7:0], max_speed[7:0],
                                                       // max_direction[8:0], average_speed[7:0],
                                                       // average_direction[8:0],
                                                       // vane_direction[8:0], vane_valid
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wsda_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsda_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SD  = wsda_pkg::SPEED_DEPTH;
    localparam int AD  = wsda_pkg::AVERAGE_DEPTH;
    localparam int SAW = wsda_pkg::SPD_AW;
    localparam int AAW = wsda_pkg::AVG_AW;
    localparam int NW  = wsda_pkg::DIV_NUM_W;
    localparam int DW  = wsda_pkg::DIV_DEN_W;
    localparam int CW  = wsda_pkg::CNT_W;
    localparam int SW  = wsda_pkg::SECTOR_W;
    localparam int GW  = wsda_pkg::DEG_W;

    // Configuration registers
    logic [15:0] spd_int_reg, spd_int_next;
    logic [23:0] avg_int_reg, avg_int_next;
    logic [4:0]  spd_win_cfg_reg, spd_win_cfg_next;
    logic [6:0]  avg_win_cfg_reg, avg_win_cfg_next;

    // Sequencer and tick state
    wsda_pkg::state_t state_reg, state_next;
    logic [15:0]      spd_timer_reg, spd_timer_next;
    logic [23:0]      avg_timer_reg, avg_timer_next;
    logic             spd_fire_reg, spd_fire_next;
    logic             avg_fire_reg, avg_fire_next;
    logic             last_level_reg, last_level_next;
    logic [CW-1:0]    cur_count_reg, cur_count_next;     // newest ring slot
    logic [SAW-1:0]   newest_reg, newest_next;
    logic [AAW-1:0]   hist_slot_reg, hist_slot_next;
    logic [CW-1:0]    cur_speed_reg, cur_speed_next;
    logic [CW-1:0]    peak_speed_reg, peak_speed_next;
    logic [SW-1:0]    peak_sector_reg, peak_sector_next;
    logic [CW-1:0]    mean_speed_reg, mean_speed_next;
    logic [GW-1:0]    mean_dir_reg, mean_dir_next;
    logic [SW-1:0]    held_sector_reg, held_sector_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [SD-1:0]    spd_vld_reg, spd_vld_next;
    logic [AD-1:0]    hist_vld_reg, hist_vld_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Per-tick payload
    logic             level_reg, level_next;
    logic             vane_ok_reg, vane_ok_next;
    logic [DW-1:0]    cnt_reg, cnt_next;
    logic [NW-1:0]    acc_a_reg, acc_a_next;           // speed sums
    logic [NW-1:0]    acc_b_reg, acc_b_next;           // degree sums
    logic [wsda_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Memories
    logic                      spd_we;
    logic [SAW-1:0]            spd_waddr, spd_raddr;
    logic [CW-1:0]             spd_wdata, spd_rdata;
    logic                      hist_we;
    logic [AAW-1:0]            hist_waddr, hist_raddr;
    logic [wsda_pkg::HIST_W-1:0] hist_wdata, hist_rdata;

    // Shared divider
    logic                  div_start;
    logic [NW-1:0]         div_num;
    logic [DW-1:0]         div_den;
    wsda_pkg::div_status_t div_status;
    logic [NW-1:0]         div_quotient;

    wsda_pkg::vane_result_t vane;

    logic [wsda_pkg::SPD_WIN_W-1:0] spd_win;
    logic [wsda_pkg::AVG_WIN_W-1:0] avg_win;
    logic                           issue;
    logic [CW-1:0]                  q_speed;
    logic [AAW-1:0]                 push_slot;

    wsda_vane u_vane (
        .sample (s_tdata[wsda_pkg::S_VANE_LSB +: wsda_pkg::VANE_W]),
        .result (vane)
    );

    wsda_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // Ring of per-interval edge counts (older slots only).
    wsda_ram #(.WIDTH(CW), .DEPTH(SD)) u_edge_ram (
        .aclk  (aclk),
        .we    (spd_we),
        .waddr (spd_waddr),
        .wdata (spd_wdata),
        .raddr (spd_raddr),
        .rdata (spd_rdata)
    );

    // History ring: {sector, speed}.
    wsda_ram #(.WIDTH(wsda_pkg::HIST_W), .DEPTH(AD)) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign spd_win   = wsda_pkg::clamp_speed_window(spd_win_cfg_reg);
    assign avg_win   = wsda_pkg::clamp_average_window(avg_win_cfg_reg);
    assign q_speed   = div_quotient[CW-1:0];
    assign push_slot = AAW'(wsda_pkg::ring_next(int'(hist_slot_reg), AD));

    assign s_tready  = (state_reg == wsda_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        spd_int_next     = spd_int_reg;
        avg_int_next     = avg_int_reg;
        spd_win_cfg_next = spd_win_cfg_reg;
        avg_win_cfg_next = avg_win_cfg_reg;
        state_next       = state_reg;
        spd_timer_next   = spd_timer_reg;
        avg_timer_next   = avg_timer_reg;
        spd_fire_next    = spd_fire_reg;
        avg_fire_next    = avg_fire_reg;
        last_level_next  = last_level_reg;
        cur_count_next   = cur_count_reg;
        newest_next      = newest_reg;
        hist_slot_next   = hist_slot_reg;
        cur_speed_next   = cur_speed_reg;
        peak_speed_next  = peak_speed_reg;
        peak_sector_next = peak_sector_reg;
        mean_speed_next  = mean_speed_reg;
        mean_dir_next    = mean_dir_reg;
        held_sector_next = held_sector_reg;
        rd_pend_next     = 1'b0;
        rd_vld_next      = 1'b0;
        spd_vld_next     = spd_vld_reg;
        hist_vld_next    = hist_vld_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        level_next       = level_reg;
        vane_ok_next     = vane_ok_reg;
        cnt_next         = cnt_reg;
        acc_a_next       = acc_a_reg;
        acc_b_next       = acc_b_reg;
        m_tdata_next     = m_tdata_reg;

        spd_we     = 1'b0;
        spd_waddr  = newest_reg;
        spd_wdata  = cur_count_reg;
        spd_raddr  = '0;
        hist_we    = 1'b0;
        hist_waddr = push_slot;
        hist_wdata = {held_sector_reg, cur_speed_reg};
        hist_raddr = '0;
        div_start  = 1'b0;
        div_num    = acc_a_reg;
        div_den    = DW'(avg_win);
        issue      = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                wsda_pkg::CFG_SPEED_INTERVAL:   spd_int_next     = cfg_data[15:0];
                wsda_pkg::CFG_AVERAGE_INTERVAL: avg_int_next     = cfg_data[23:0];
                wsda_pkg::CFG_SPEED_WINDOW:     spd_win_cfg_next = cfg_data[4:0];
                wsda_pkg::CFG_AVERAGE_WINDOW:   avg_win_cfg_next = cfg_data[6:0];
                default: ;
            endcase
        end

        case (state_reg)
            wsda_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    // Classify, clear the maximum on request, advance both interval timers.
                    if (vane.match) begin
                        held_sector_next = vane.sector;
                    end
                    vane_ok_next = vane.match;
                    level_next   = s_tdata[wsda_pkg::S_LEVEL_BIT];
                    if (s_tdata[wsda_pkg::S_CLEAR_BIT]) begin
                        peak_speed_next = '0;
                    end
                    spd_fire_next  = (spd_timer_reg >= spd_int_reg);
                    avg_fire_next  = (avg_timer_reg >= avg_int_reg);
                    spd_timer_next = spd_fire_next ? 16'd0 : spd_timer_reg + 16'd1;
                    avg_timer_next = avg_fire_next ? 24'd0 : avg_timer_reg + 24'd1;
                    acc_a_next     = NW'(cur_count_reg);
                    cnt_next       = DW'(1);
                    if (spd_fire_next) begin
                        state_next = wsda_pkg::ST_SPD_SUM;
                    end else if (avg_fire_next) begin
                        state_next = wsda_pkg::ST_AVG_PUSH;
                    end else begin
                        state_next = wsda_pkg::ST_FINISH;
                    end
                end
            end

            wsda_pkg::ST_SPD_SUM: begin
                // Read one older slot per cycle and add it in the following cycle.
                issue     = (cnt_reg < DW'(spd_win));
                spd_raddr = SAW'(wsda_pkg::ring_back(int'(newest_reg), int'(cnt_reg), SD));
                if (issue) begin
                    cnt_next = cnt_reg + DW'(1);
                end
                rd_pend_next = issue;
                rd_vld_next  = spd_vld_reg[spd_raddr];
                if (rd_pend_reg && rd_vld_reg) begin
                    acc_a_next = acc_a_reg + NW'(spd_rdata);
                end
                if (!issue && !rd_pend_reg) begin
                    div_start  = 1'b1;
                    div_num    = acc_a_reg;
                    div_den    = DW'(spd_win);
                    state_next = wsda_pkg::ST_SPD_DIV;
                end
            end

            wsda_pkg::ST_SPD_DIV: begin
                if (div_status.done) begin
                    cur_speed_next = q_speed;
                    if (q_speed > peak_speed_reg) begin
                        peak_speed_next  = q_speed;
                        peak_sector_next = held_sector_reg;
                    end
                    // Retire the newest slot into the ring and open a fresh one.
                    spd_we                   = 1'b1;
                    spd_vld_next[newest_reg] = 1'b1;
                    newest_next    = SAW'(wsda_pkg::ring_next(int'(newest_reg), SD));
                    cur_count_next = '0;
                    state_next     = avg_fire_reg ? wsda_pkg::ST_AVG_PUSH
                                                  : wsda_pkg::ST_FINISH;
                end
            end

            wsda_pkg::ST_AVG_PUSH: begin
                hist_we                  = 1'b1;
                hist_vld_next[push_slot] = 1'b1;
                hist_slot_next           = push_slot;
                cnt_next                 = '0;
                acc_a_next               = '0;
                acc_b_next               = '0;
                state_next               = wsda_pkg::ST_AVG_SUM;
            end

            wsda_pkg::ST_AVG_SUM: begin
                issue      = (cnt_reg < DW'(avg_win));
                hist_raddr = AAW'(wsda_pkg::ring_back(int'(hist_slot_reg), int'(cnt_reg), AD));
                if (issue) begin
                    cnt_next = cnt_reg + DW'(1);
                end
                rd_pend_next = issue;
                rd_vld_next  = hist_vld_reg[hist_raddr];
                if (rd_pend_reg && rd_vld_reg) begin
                    acc_a_next = acc_a_reg + NW'(hist_rdata[CW-1:0]);
                    acc_b_next = acc_b_reg
                               + NW'(wsda_pkg::sector_degrees(hist_rdata[CW +: SW]));
                end
                if (!issue && !rd_pend_reg) begin
                    div_start  = 1'b1;
                    div_num    = acc_a_reg;
                    state_next = wsda_pkg::ST_AVG_DIV_SPD;
                end
            end

            wsda_pkg::ST_AVG_DIV_SPD: begin
                if (div_status.done) begin
                    mean_speed_next = q_speed;
                    div_start       = 1'b1;
                    div_num         = acc_b_reg;
                    state_next      = wsda_pkg::ST_AVG_DIV_DIR;
                end
            end

            wsda_pkg::ST_AVG_DIV_DIR: begin
                if (div_status.done) begin
                    mean_dir_next = div_quotient[GW-1:0];
                    state_next    = wsda_pkg::ST_FINISH;
                end
            end

            wsda_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0,
                                     vane_ok_reg,
                                     wsda_pkg::sector_degrees(held_sector_reg),
                                     mean_dir_reg,
                                     mean_speed_reg,
                                     wsda_pkg::sector_degrees(peak_sector_reg),
                                     peak_speed_reg,
                                     cur_speed_reg};
                    // Edge count last, so an edge on an update tick lands in the fresh slot.
                    if (level_reg != last_level_reg) begin
                        last_level_next = level_reg;
                        if (level_reg && (cur_count_reg != 8'hFF)) begin
                            cur_count_next = cur_count_reg + 8'd1;
                        end
                    end
                    state_next = wsda_pkg::ST_IDLE;
                end
            end

            default: state_next = wsda_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_int_reg     <= 16'd1000;
            avg_int_reg     <= 24'd60000;
            spd_win_cfg_reg <= 5'd8;
            avg_win_cfg_reg <= 7'd16;
            state_reg       <= wsda_pkg::ST_IDLE;
            spd_timer_reg   <= '0;
            avg_timer_reg   <= '0;
            spd_fire_reg    <= 1'b0;
            avg_fire_reg    <= 1'b0;
            last_level_reg  <= 1'b0;
            cur_count_reg   <= '0;
            newest_reg      <= '0;
            hist_slot_reg   <= '0;
            cur_speed_reg   <= '0;
            peak_speed_reg  <= '0;
            peak_sector_reg <= '0;
            mean_speed_reg  <= '0;
            mean_dir_reg    <= '0;
            held_sector_reg <= '0;
            rd_pend_reg     <= 1'b0;
            rd_vld_reg      <= 1'b0;
            spd_vld_reg     <= '0;
            hist_vld_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            spd_int_reg     <= spd_int_next;
            avg_int_reg     <= avg_int_next;
            spd_win_cfg_reg <= spd_win_cfg_next;
            avg_win_cfg_reg <= avg_win_cfg_next;
            state_reg       <= state_next;
            spd_timer_reg   <= spd_timer_next;
            avg_timer_reg   <= avg_timer_next;
            spd_fire_reg    <= spd_fire_next;
            avg_fire_reg    <= avg_fire_next;
            last_level_reg  <= last_level_next;
            cur_count_reg   <= cur_count_next;
            newest_reg      <= newest_next;
            hist_slot_reg   <= hist_slot_next;
            cur_speed_reg   <= cur_speed_next;
            peak_speed_reg  <= peak_speed_next;
            peak_sector_reg <= peak_sector_next;
            mean_speed_reg  <= mean_speed_next;
            mean_dir_reg    <= mean_dir_next;
            held_sector_reg <= held_sector_next;
            rd_pend_reg     <= rd_pend_next;
            rd_vld_reg      <= rd_vld_next;
            spd_vld_reg     <= spd_vld_next;
            hist_vld_reg    <= hist_vld_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg   <= level_next;
        vane_ok_reg <= vane_ok_next;
        cnt_reg     <= cnt_next;
        acc_a_reg   <= acc_a_next;
        acc_b_reg   <= acc_b_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Checks
    `WSDA_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input accepted again before the tick finished")
    `WSDA_ASSERT(a_div_start_idle, aclk, aresetn, div_start |-> !div_status.busy, "divider started while busy")
    `WSDA_ASSERT(a_result_from_finish, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg == wsda_pkg::ST_FINISH), "result raised outside the finish step")
    `WSDA_ASSERT_ANY(a_reset_quiet, aclk, !aresetn |=> (!m_tvalid && s_tready), "block not idle after reset")

endmodule

[tb/wind_speed_direction_averager_test.sv]
module wind_speed_direction_averager_test;

    localparam int SPEED_SLOTS    = wsda_pkg::SPEED_DEPTH;    // edge count ring depth
    localparam int HISTORY_SLOTS  = wsda_pkg::AVERAGE_DEPTH;  // speed / sector history depth
    localparam int DEG_PER_SECTOR = 45;
    localparam int VANE_TOL_LSB   = 10;     // match when distance is strictly below this
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no transaction on any channel
    localparam int TAIL_CYCLES    = 150;    // longer than the worst tick
    localparam int REPORT_LIMIT   = 10;

    // Compass sectors, numbered clockwise from north.
    typedef enum int {
        SEC_N, SEC_NE, SEC_E, SEC_SE, SEC_S, SEC_SW, SEC_W, SEC_NW
    } sector_t;

    typedef struct packed {
        logic [7:0] wind_speed;
        logic [7:0] max_speed;
        logic [8:0] max_direction;
        logic [7:0] average_speed;
        logic [8:0] average_direction;
        logic [8:0] vane_direction;
        logic       vane_valid;
    } wind_report_t;

    // Tracks the averager state per tick and holds the reports still owed by the block.
    class wind_scoreboard;
        int speed_interval;
        int average_interval;
        int speed_window;
        int average_window;

        int edge_counts[SPEED_SLOTS];
        int newest_slot;
        int speed_history[HISTORY_SLOTS];
        int sector_history[HISTORY_SLOTS];
        int history_slot;
        int speed_timer;
        int average_timer;
        bit last_level;
        int current_speed;
        int peak_speed;
        int peak_sector;
        int mean_speed;
        int mean_direction;
        int held_sector;

        wind_report_t expected_reports[$];
        int mismatches;

        function new();
            speed_interval   = 1000;
            average_interval = 60000;
            speed_window     = 8;
            average_window   = 16;
            foreach (edge_counts[i]) edge_counts[i] = 0;
            foreach (speed_history[i]) begin
                speed_history[i]  = 0;
                sector_history[i] = 0;
            end
            newest_slot    = 0;
            history_slot   = 0;
            speed_timer    = 0;
            average_timer  = 0;
            last_level     = 1'b0;
            current_speed  = 0;
            peak_speed     = 0;
            peak_sector    = SEC_N;
            mean_speed     = 0;
            mean_direction = 0;
            held_sector    = SEC_N;
            mismatches     = 0;
        endfunction

        // Vane references in the order they are tried.
        static function void vane_reference(int i, output int point, output int sector);
            case (i)
                0:       begin point = 0;   sector = SEC_W;  end
                1:       begin point = 692; sector = SEC_NW; end
                2:       begin point = 554; sector = SEC_N;  end
                3:       begin point = 226; sector = SEC_NE; end
                4:       begin point = 35;  sector = SEC_E;  end
                5:       begin point = 66;  sector = SEC_SE; end
                6:       begin point = 122; sector = SEC_S;  end
                default: begin point = 366; sector = SEC_SW; end
            endcase
        endfunction

        static function bit match_vane(int vane, output int sector);
            int point;
            int candidate;
            int delta;
            sector = SEC_N;
            for (int i = 0; i < 8; i++) begin
                vane_reference(i, point, candidate);
                delta = (vane >= point) ? vane - point : point - vane;
                if (delta < VANE_TOL_LSB) begin
                    sector = candidate;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        static function int clamp_window(int w, int depth);
            if (w == 0) return 1;
            if (w > depth) return depth;
            return w;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void set_register(wsda_pkg::cfg_index_t idx, logic [23:0] value);
            case (idx)
                wsda_pkg::CFG_SPEED_INTERVAL:   speed_interval   = int'(value[15:0]);
                wsda_pkg::CFG_AVERAGE_INTERVAL: average_interval = int'(value[23:0]);
                wsda_pkg::CFG_SPEED_WINDOW:     speed_window     = int'(value[4:0]);
                wsda_pkg::CFG_AVERAGE_WINDOW:   average_window   = int'(value[6:0]);
                default: ;
            endcase
        endfunction

        // Advances one millisecond tick and queues the report it produces.
        function void note_tick(bit level, int vane, bit clear);
            int sector;
            bit valid;
            int w;
            int sum;
            int dsum;
            wind_report_t rpt;

            valid = match_vane(vane, sector);
            if (valid) held_sector = sector;
            if (clear) peak_speed = 0;

            // speed interval: mean over the newest w counts, then open a fresh slot
            if (speed_timer + 1 > speed_interval) begin
                speed_timer = 0;
                w = clamp_window(speed_window, SPEED_SLOTS);
                sum = 0;
                for (int k = 0; k < w; k++)
                    sum += edge_counts[(newest_slot + SPEED_SLOTS - k) % SPEED_SLOTS];
                current_speed = sum / w;
                if (current_speed > peak_speed) begin
                    peak_speed  = current_speed;
                    peak_sector = held_sector;
                end
                newest_slot = (newest_slot + 1) % SPEED_SLOTS;
                edge_counts[newest_slot] = 0;
            end else begin
                speed_timer++;
            end

            // average interval: push speed and sector, then average the window
            if (average_timer + 1 > average_interval) begin
                average_timer = 0;
                history_slot = (history_slot + 1) % HISTORY_SLOTS;
                speed_history[history_slot]  = current_speed;
                sector_history[history_slot] = held_sector;
                w = clamp_window(average_window, HISTORY_SLOTS);
                sum  = 0;
                dsum = 0;
                for (int k = 0; k < w; k++) begin
                    sum  += speed_history[(history_slot + HISTORY_SLOTS - k) % HISTORY_SLOTS];
                    dsum += sector_history[(history_slot + HISTORY_SLOTS - k) % HISTORY_SLOTS];
                end
                mean_speed     = sum / w;
                mean_direction = (dsum * DEG_PER_SECTOR) / w;
            end else begin
                average_timer++;
            end

            // rising edge counts into the (possibly fresh) newest slot, saturating
            if (level != last_level) begin
                last_level = level;
                if (level && edge_counts[newest_slot] < 255) edge_counts[newest_slot]++;
            end

            rpt.wind_speed        = 8'(current_speed);
            rpt.max_speed         = 8'(peak_speed);
            rpt.max_direction     = 9'(peak_sector * DEG_PER_SECTOR);
            rpt.average_speed     = 8'(mean_speed);
            rpt.average_direction = 9'(mean_direction);
            rpt.vane_direction    = 9'(held_sector * DEG_PER_SECTOR);
            rpt.vane_valid        = valid;
            expected_reports.push_back(rpt);
        endfunction

        function void check_result(logic [wsda_pkg::M_TDATA_W-1:0] word);
            wind_report_t got;
            wind_report_t want;
            bit bad;
            got.wind_speed        = word[7:0];
            got.max_speed         = word[15:8];
            got.max_direction     = word[24:16];
            got.average_speed     = word[32:25];
            got.average_direction = word[41:33];
            got.vane_direction    = word[50:42];
            got.vane_valid        = word[51];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected wind report %h with nothing outstanding", word);
                return;
            end
            want = expected_reports.pop_front();
            bad = (got.wind_speed !== want.wind_speed)
                || (got.max_speed !== want.max_speed)
                || (got.max_direction !== want.max_direction)
                || (got.average_speed !== want.average_speed)
                || (got.average_direction !== want.average_direction)
                || (got.vane_direction !== want.vane_direction)
                || (got.vane_valid !== want.vane_valid);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("wind report mismatch, expected spd=%0d max=%0d maxdir=%0d avg=%0d",
                             want.wind_speed, want.max_speed, want.max_direction,
                             want.average_speed);
                    $display("    avgdir=%0d dir=%0d valid=%0d; actual spd=%0d max=%0d maxdir=%0d",
                             want.average_direction, want.vane_direction, want.vane_valid,
                             got.wind_speed, got.max_speed, got.max_direction);
                    $display("    avg=%0d avgdir=%0d dir=%0d valid=%0d",
                             got.average_speed, got.average_direction, got.vane_direction,
                             got.vane_valid);
                end
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [wsda_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [wsda_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    wsda_pkg::cfg_index_t            cfg_index = wsda_pkg::CFG_SPEED_INTERVAL;
    logic [wsda_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    wind_scoreboard sb = new();
    bit steady_sender = 1'b0;       // no gaps on the tick side while set
    int quiet_cycles  = 0;

    wind_speed_direction_averager i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Most samples land near a reference (inside or just outside the tolerance band),
    // the rest anywhere on the converter range.
    function automatic int pick_vane();
        int point;
        int sector;
        int v;
        if ($urandom_range(0, 9) < 7) begin
            wind_scoreboard::vane_reference($urandom_range(0, 7), point, sector);
            v = point + int'($urandom_range(0, 24)) - 12;
            if (v < 0) v = 0;
        end else begin
            v = $urandom_range(0, 1023);
        end
        return v;
    endfunction

    // Result side: bursts of ready, broken by random stalls; sometimes long clean runs.
    initial begin
        int run;
        int hold;
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            hold = pick_gap();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Watchdog: no transaction on any channel for too long ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("wind_speed_direction_averager_test: FAIL");
            $finish;
        end
    end

    // One tick transaction. Valid stays high on return so back-to-back ticks need
    // no extra edge; the tick is handed to the scoreboard at its accepting edge.
    task automatic send_tick(bit level, int vane, bit clear);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, clear, vane[9:0], level};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(level, vane, clear);
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_register(wsda_pkg::cfg_index_t idx,
                                  logic [wsda_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, value);
    endtask

    // Registers change only with the block idle: drop the tick valid, drain, settle.
    task automatic configure(int spd_ivl, int avg_ivl, int spd_win, int avg_win);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_for_results();
        repeat (4) @(posedge aclk);
        write_register(wsda_pkg::CFG_SPEED_INTERVAL, wsda_pkg::CFG_DATA_W'(spd_ivl));
        write_register(wsda_pkg::CFG_AVERAGE_INTERVAL, wsda_pkg::CFG_DATA_W'(avg_ivl));
        write_register(wsda_pkg::CFG_SPEED_WINDOW, wsda_pkg::CFG_DATA_W'(spd_win));
        write_register(wsda_pkg::CFG_AVERAGE_WINDOW, wsda_pkg::CFG_DATA_W'(avg_win));
        cfg_valid <= 1'b0;
    endtask

    // Random ticks. With toggle_level set the anemometer flips every tick, which
    // piles rising edges into one slot, whose count saturates at 255.
    task automatic run_phase(int count, bit toggle_level);
        bit level;
        bit clear;
        for (int i = 0; i < count; i++) begin
            level = toggle_level ? i[0] : 1'($urandom_range(0, 1));
            clear = toggle_level ? 1'b0 : ($urandom_range(0, 15) == 0);
            if (!toggle_level && $urandom_range(0, 39) == 0) begin
                // hold off until the block has caught up completely
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait_for_results();
            end
            send_tick(level, pick_vane(), clear);
        end
    endtask

    initial begin
        int probes[19];
        int spd_win;
        int avg_win;

        probes = '{0, 692, 554, 226, 35, 66, 122, 366, 1023, 9, 10,
                   683, 682, 563, 564, 217, 375, 376, 1013};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks at reset settings: every reference exactly, band edges on
        // both sides, converter extremes, clears, and the level toggling.
        for (int i = 0; i < 25; i++)
            send_tick(i[0], (i < 19) ? probes[i] : pick_vane(), (i == 5) || (i == 20));

        // Zero intervals fire every tick; zero windows count as one.
        configure(0, 0, 0, 0);
        run_phase(60, 1'b0);

        // Full-depth windows with short intervals.
        configure(1, 2, 16, 64);
        run_phase(60, 1'b0);

        // Register maxima: intervals never elapse here, windows clamp to depth.
        steady_sender = 1'b1;
        configure(65535, 16777215, 31, 127);
        run_phase(20, 1'b0);
        steady_sender = 1'b0;

        // Long speed interval with a toggling anemometer piles edges into one slot.
        configure(515, 3, 2, 65);
        run_phase(520, 1'b1);

        // Random settings; window data sometimes carries junk above the field.
        for (int p = 0; p < 4; p++) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            spd_win = $urandom_range(0, 31);
            avg_win = $urandom_range(0, 127);
            if ($urandom_range(0, 1) == 1) begin
                spd_win = spd_win | int'($urandom_range(0, 16'hFFFF) << 5);
                avg_win = avg_win | int'($urandom_range(0, 16'hFFFF) << 7);
            end
            configure($urandom_range(0, 6), $urandom_range(0, 12), spd_win, avg_win);
            run_phase(45, 1'b0);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("wind_speed_direction_averager_test: PASS");
        end else begin
            $display("wind_speed_direction_averager_test: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/wsda_pkg.sv
rtl/wsda_ram.sv
rtl/wsda_vane.sv
rtl/wsda_divider.sv
rtl/wind_speed_direction_averager.sv
tb/wind_speed_direction_averager_test.sv
